@@ design/slea_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package slea_pkg;

    localparam int PIXEL_COUNT_DEF = 8;
    localparam int BAR_SHOWN       = 8;

    localparam int RPM_W      = 14;
    localparam int MS_W       = 10;
    localparam int ELAPSED_W  = 11;
    localparam int PHASE_W    = 10;
    localparam int CHAN_W     = 8;
    localparam int VALUE_W    = 16;
    localparam int CODE_W     = 3;
    localparam int CODES_W    = 24;
    localparam int COUNT_W    = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [CODE_W-1:0] {
        PX_OFF   = 3'd0,
        PX_GREEN = 3'd1,
        PX_AMBER = 3'd2,
        PX_RED   = 3'd3,
        PX_DIM   = 3'd4
    } px_code_t;

    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_t;

    localparam logic [CHAN_W-1:0] CH_RPM   = 8'd1;
    localparam logic [CHAN_W-1:0] CH_MAP   = 8'd2;
    localparam logic [CHAN_W-1:0] CH_BAT   = 8'd5;
    localparam logic [CHAN_W-1:0] CH_CLT   = 8'd24;
    localparam logic [CHAN_W-1:0] CH_FAULT = 8'd255;

    localparam logic [CFG_ADDR_W-1:0] REG_START_RPM   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_END_RPM     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_POINT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DARK_POINT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_AMBER_MS    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FLASH_MS    = 3'd5;

    localparam logic [RPM_W-1:0] START_RPM_RST   = 14'd1200;
    localparam logic [RPM_W-1:0] END_RPM_RST     = 14'd6200;
    localparam logic [RPM_W-1:0] SHIFT_POINT_RST = 14'd4200;
    localparam logic [RPM_W-1:0] DARK_POINT_RST  = 14'd4700;
    localparam logic [MS_W-1:0]  AMBER_MS_RST    = 10'd120;
    localparam logic [MS_W-1:0]  FLASH_MS_RST    = 10'd300;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 11'd2047;
    localparam logic [PHASE_W-1:0]   BUZZ_LAST   = 10'd599;
    localparam logic [PHASE_W-1:0]   BUZZ_ON     = 10'd300;
    localparam logic [VALUE_W-1:0]   FAULT_MASK  = 16'h070F;
    localparam logic [VALUE_W-1:0]   CLT_LIMIT   = 16'd105;
    localparam logic [VALUE_W-1:0]   RPM_LIMIT   = 16'd7000;
    localparam logic [VALUE_W-1:0]   MAP_LIMIT   = 16'd212;
    localparam logic [VALUE_W-1:0]   BAT_LOW     = 16'd38;
    localparam logic [VALUE_W-1:0]   BAT_HIGH    = 16'd443;

    typedef struct packed {
        cmd_t               command;
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [RPM_W-1:0] start_rpm;
        logic [RPM_W-1:0] shift_point;
        logic [RPM_W-1:0] dark_point;
        logic [MS_W-1:0]  amber_interval_ms;
        logic [MS_W-1:0]  screen_flash_ms;
        logic [RPM_W-1:0] step_rpm;
    } cfg_t;

    typedef struct packed {
        logic [CODES_W-1:0] pixel_codes;
        logic               buzzer;
        logic               alarm;
        logic               screen_flash;
        logic [COUNT_W-1:0] fault_count;
    } result_t;

endpackage

`default_nettype wire

@@ design/slea_in_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slea_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire slea_pkg::item_t s_item,
    input  wire logic           take,
    output logic                item_valid,
    output slea_pkg::item_t     item
);
    import slea_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

@@ design/slea_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slea_core #(
    parameter int PIXEL_COUNT = slea_pkg::PIXEL_COUNT_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            fire,
    input  wire slea_pkg::item_t item,
    input  wire slea_pkg::cfg_t  cfg,
    output slea_pkg::result_t    result
);
    import slea_pkg::*;

    localparam int SHOWN = (PIXEL_COUNT < BAR_SHOWN) ? PIXEL_COUNT : BAR_SHOWN;

    logic [VALUE_W-1:0]   engine_speed_reg, engine_speed_next;
    logic [VALUE_W-1:0]   coolant_raw_reg, coolant_raw_next;
    logic [VALUE_W-1:0]   manifold_raw_reg, manifold_raw_next;
    logic [VALUE_W-1:0]   battery_raw_reg, battery_raw_next;
    logic [COUNT_W-1:0]   faults_seen_reg, faults_seen_next;
    px_code_t             pixel_reg [PIXEL_COUNT];
    px_code_t             pixel_next [PIXEL_COUNT];
    logic                 amber_on_reg, amber_on_next;
    logic [ELAPSED_W-1:0] amber_elapsed_reg, amber_elapsed_next;
    logic                 flash_active_reg, flash_active_next;
    logic [ELAPSED_W-1:0] flash_elapsed_reg, flash_elapsed_next;
    logic [PHASE_W-1:0]   buzz_phase_reg, buzz_phase_next;

    px_code_t             graph_code [PIXEL_COUNT];
    logic [COUNT_W-1:0]   fault_ones;
    logic                 below_shift;
    logic                 below_flash_end;
    logic                 alarm;
    logic [CODES_W-1:0]   codes;

    // Bar graph thresholds: pixel g lights when rpm exceeds start + g * step.
    for (genvar g = 0; g < PIXEL_COUNT; g++) begin : g_graph
        localparam int       K      = (g * 8) / PIXEL_COUNT;
        localparam px_code_t COLOUR = (K < 4) ? PX_GREEN : ((K < 6) ? PX_AMBER : PX_RED);
        logic [VALUE_W-1:0] threshold;
        assign threshold = VALUE_W'(cfg.start_rpm)
                         + VALUE_W'(g) * VALUE_W'(cfg.step_rpm);
        assign graph_code[g] = (item.value > threshold) ? COLOUR : PX_OFF;
    end

    assign fault_ones      = COUNT_W'($countones(item.value & FAULT_MASK));
    assign below_shift     = item.value < VALUE_W'(cfg.shift_point);
    assign below_flash_end = item.value < VALUE_W'(cfg.dark_point);

    always_comb begin
        engine_speed_next  = engine_speed_reg;
        coolant_raw_next   = coolant_raw_reg;
        manifold_raw_next  = manifold_raw_reg;
        battery_raw_next   = battery_raw_reg;
        faults_seen_next   = faults_seen_reg;
        pixel_next         = pixel_reg;
        amber_on_next      = amber_on_reg;
        amber_elapsed_next = amber_elapsed_reg;
        flash_active_next  = flash_active_reg;
        flash_elapsed_next = flash_elapsed_reg;
        buzz_phase_next    = buzz_phase_reg;
        if (fire) begin
            if (item.command == CMD_TICK) begin
                if (amber_elapsed_reg != ELAPSED_MAX) begin
                    amber_elapsed_next = amber_elapsed_reg + 1'b1;
                end
                if (flash_elapsed_reg != ELAPSED_MAX) begin
                    flash_elapsed_next = flash_elapsed_reg + 1'b1;
                end
                buzz_phase_next = (buzz_phase_reg == BUZZ_LAST) ? '0 : buzz_phase_reg + 1'b1;
                if (flash_active_reg
                    && flash_elapsed_next > ELAPSED_W'(cfg.screen_flash_ms)) begin
                    flash_active_next = 1'b0;
                end
            end else begin
                unique case (item.channel)
                    CH_RPM: begin
                        engine_speed_next = item.value;
                        if (!below_shift && !flash_active_reg) begin
                            flash_active_next  = 1'b1;
                            flash_elapsed_next = '0;
                        end
                        if (below_shift) begin
                            pixel_next = graph_code;
                        end else if (below_flash_end) begin
                            if (amber_elapsed_reg > ELAPSED_W'(cfg.amber_interval_ms)) begin
                                amber_on_next      = !amber_on_reg;
                                amber_elapsed_next = '0;
                                for (int i = 0; i < PIXEL_COUNT; i++) begin
                                    pixel_next[i] = amber_on_reg ? PX_OFF : PX_AMBER;
                                end
                            end
                        end else begin
                            for (int i = 0; i < PIXEL_COUNT; i++) begin
                                pixel_next[i] = PX_OFF;
                            end
                        end
                    end
                    CH_MAP:   manifold_raw_next = item.value;
                    CH_BAT:   battery_raw_next  = item.value;
                    CH_CLT:   coolant_raw_next  = item.value;
                    CH_FAULT: faults_seen_next  = fault_ones;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            engine_speed_reg  <= '0;
            coolant_raw_reg   <= '0;
            manifold_raw_reg  <= '0;
            battery_raw_reg   <= '0;
            faults_seen_reg   <= '0;
            for (int i = 0; i < PIXEL_COUNT; i++) begin
                pixel_reg[i] <= PX_DIM;
            end
            amber_on_reg      <= 1'b0;
            amber_elapsed_reg <= '0;
            flash_active_reg  <= 1'b0;
            flash_elapsed_reg <= '0;
            buzz_phase_reg    <= '0;
        end else begin
            engine_speed_reg  <= engine_speed_next;
            coolant_raw_reg   <= coolant_raw_next;
            manifold_raw_reg  <= manifold_raw_next;
            battery_raw_reg   <= battery_raw_next;
            faults_seen_reg   <= faults_seen_next;
            pixel_reg         <= pixel_next;
            amber_on_reg      <= amber_on_next;
            amber_elapsed_reg <= amber_elapsed_next;
            flash_active_reg  <= flash_active_next;
            flash_elapsed_reg <= flash_elapsed_next;
            buzz_phase_reg    <= buzz_phase_next;
        end
    end

    assign alarm = (faults_seen_next != '0)
                || (coolant_raw_next > CLT_LIMIT)
                || (engine_speed_next > RPM_LIMIT)
                || (manifold_raw_next >= MAP_LIMIT)
                || ((battery_raw_next >= BAT_LOW) && (battery_raw_next <= BAT_HIGH));

    always_comb begin
        codes = '0;
        for (int i = 0; i < SHOWN; i++) begin
            codes[CODE_W*i +: CODE_W] = pixel_next[i];
        end
    end

    assign result.pixel_codes  = codes;
    assign result.buzzer       = alarm && (buzz_phase_next < BUZZ_ON);
    assign result.alarm        = alarm;
    assign result.screen_flash = flash_active_next;
    assign result.fault_count  = faults_seen_next;

endmodule

`default_nettype wire

@@ design/slea_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slea_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    output logic                   can_load,
    input  wire logic              load,
    input  wire slea_pkg::result_t result,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output slea_pkg::result_t      m_result
);
    import slea_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

@@ design/shift_light_and_engine_alarm.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                       Direction
// input     s_valid s_ready s_command s_channel s_value   in
// result    m_valid m_ready m_pixel_codes m_buzzer ...    out
// config    cfg_wr_en cfg_addr cfg_wr_data                in
//
// A request is taken every cycle unless m_ready stalls; its result is registered to m_.
// The input register feeds the state update, whose result lands in the output register.
// Reset is synchronous and active low and clears the state to its power-up values.
// A stalled result holds in the output register while the input register still fills.
// The bar step is registered from the configuration and lags a write by that register.

module shift_light_and_engine_alarm #(
    parameter int PIXEL_COUNT = slea_pkg::PIXEL_COUNT_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_command,
    input  wire logic [slea_pkg::CHAN_W-1:0]        s_channel,
    input  wire logic [slea_pkg::VALUE_W-1:0]       s_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [slea_pkg::CODES_W-1:0]            m_pixel_codes,
    output logic                                    m_buzzer,
    output logic                                    m_alarm,
    output logic                                    m_screen_flash,
    output logic [slea_pkg::COUNT_W-1:0]            m_fault_count,
    input  wire logic                               cfg_wr_en,
    input  wire logic [slea_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [slea_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import slea_pkg::*;

    localparam int DIV_SHIFT = RPM_W + $clog2(PIXEL_COUNT);
    localparam int RECIP     = ((1 << DIV_SHIFT) + PIXEL_COUNT - 1) / PIXEL_COUNT;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = RPM_W + RECIP_W;

    logic [RPM_W-1:0]  start_rpm_reg, end_rpm_reg, shift_point_reg, dark_point_reg;
    logic [MS_W-1:0]   amber_ms_reg, flash_ms_reg;
    logic [RPM_W-1:0]  step_reg, step_next;
    logic [RPM_W-1:0]  span;
    logic [PROD_W-1:0] span_prod;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    logic    can_load;
    cfg_t    cfg;
    result_t result;
    result_t m_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_rpm_reg   <= START_RPM_RST;
            end_rpm_reg     <= END_RPM_RST;
            shift_point_reg <= SHIFT_POINT_RST;
            dark_point_reg  <= DARK_POINT_RST;
            amber_ms_reg    <= AMBER_MS_RST;
            flash_ms_reg    <= FLASH_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_START_RPM:   start_rpm_reg   <= cfg_wr_data[RPM_W-1:0];
                REG_END_RPM:     end_rpm_reg     <= cfg_wr_data[RPM_W-1:0];
                REG_SHIFT_POINT: shift_point_reg <= cfg_wr_data[RPM_W-1:0];
                REG_DARK_POINT:  dark_point_reg  <= cfg_wr_data[RPM_W-1:0];
                REG_AMBER_MS:    amber_ms_reg    <= cfg_wr_data[MS_W-1:0];
                REG_FLASH_MS:    flash_ms_reg    <= cfg_wr_data[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The span is divided by the pixel count through an exact reciprocal multiply.
    assign span      = (end_rpm_reg >= start_rpm_reg) ? (end_rpm_reg - start_rpm_reg) : '0;
    assign span_prod = PROD_W'(span) * PROD_W'(RECIP_W'(RECIP));
    assign step_next = span_prod[DIV_SHIFT +: RPM_W];

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
    end

    assign cfg.start_rpm         = start_rpm_reg;
    assign cfg.shift_point       = shift_point_reg;
    assign cfg.dark_point        = dark_point_reg;
    assign cfg.amber_interval_ms = amber_ms_reg;
    assign cfg.screen_flash_ms   = flash_ms_reg;
    assign cfg.step_rpm          = step_reg;

    assign s_item.command = cmd_t'(s_command);
    assign s_item.channel = s_channel;
    assign s_item.value   = s_value;

    assign take = item_valid && can_load;

    slea_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    slea_core #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (take),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    slea_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .can_load (can_load),
        .load     (take),
        .result   (result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_pixel_codes  = m_result.pixel_codes;
    assign m_buzzer       = m_result.buzzer;
    assign m_alarm        = m_result.alarm;
    assign m_screen_flash = m_result.screen_flash;
    assign m_fault_count  = m_result.fault_count;

endmodule

`default_nettype wire

@@ design/slea_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slea_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [slea_pkg::CODES_W-1:0]    m_pixel_codes,
    input wire logic                            m_buzzer,
    input wire logic                            m_alarm,
    input wire logic                            m_screen_flash,
    input wire logic [slea_pkg::COUNT_W-1:0]    m_fault_count
);
    import slea_pkg::*;

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result request dropped while stalled");

    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable({m_pixel_codes, m_buzzer, m_alarm,
                                         m_screen_flash, m_fault_count}))
        else $error("result request changed while stalled");

    a_buzzer_needs_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_buzzer |-> m_alarm)
        else $error("buzzer on without an alarm");

    a_faults_raise_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_fault_count != '0) |-> m_alarm)
        else $error("fault count without an alarm");

    a_ready_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> s_ready && !m_valid)
        else $error("block not empty after reset");

endmodule

bind shift_light_and_engine_alarm slea_checker u_slea_checker (.*);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import slea_pkg::*;

    localparam int BAR_LEN       = PIXEL_COUNT_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;

    localparam logic [CODES_W-1:0] BAR_DIM  = {8{PX_DIM}};
    localparam logic [CODES_W-1:0] BAR_DARK = '0;

    typedef struct packed {
        item_t   req;
        logic    typed;
        result_t want;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_command;
    logic [CHAN_W-1:0]     s_channel;
    logic [VALUE_W-1:0]    s_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [CODES_W-1:0]    m_pixel_codes;
    logic                  m_buzzer;
    logic                  m_alarm;
    logic                  m_screen_flash;
    logic [COUNT_W-1:0]    m_fault_count;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    // Register mirror and dashboard state used to forecast each status word.
    logic [RPM_W-1:0]     lim_start, lim_end, lim_shift, lim_dark;
    logic [MS_W-1:0]      lim_amber, lim_flash;
    logic [VALUE_W-1:0]   rpm_now, coolant_now, map_now, battery_now;
    logic [COUNT_W-1:0]   fault_bits;
    px_code_t             lamps [BAR_LEN];
    logic                 amber_lit, flash_on;
    logic [ELAPSED_W-1:0] amber_age, flash_age;
    logic [PHASE_W-1:0]   buzz_ms;

    result_t   dash_due [$];
    result_t   due_now;
    stim_row_t dir_rows [$];
    int        mismatches  = 0;
    int        cycle_count = 0;
    int        sent_count  = 0;
    logic      sender_calm = 1'b0;

    shift_light_and_engine_alarm #(
        .PIXEL_COUNT(BAR_LEN)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_channel     (s_channel),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_codes (m_pixel_codes),
        .m_buzzer      (m_buzzer),
        .m_alarm       (m_alarm),
        .m_screen_flash(m_screen_flash),
        .m_fault_count (m_fault_count),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    function automatic void fill_lamps(px_code_t code);
        for (int i = 0; i < BAR_LEN; i++) begin
            lamps[i] = code;
        end
    endfunction

    function automatic result_t dash_step(item_t req);
        result_t r;
        int      step;
        int      k;
        logic    alarm_now;
        r = '0;
        if (req.command == CMD_TICK) begin
            if (amber_age != ELAPSED_MAX) amber_age = amber_age + 1'b1;
            if (flash_age != ELAPSED_MAX) flash_age = flash_age + 1'b1;
            if (buzz_ms == BUZZ_LAST) begin
                buzz_ms = '0;
            end else begin
                buzz_ms = buzz_ms + 1'b1;
            end
            if (flash_on && flash_age > lim_flash) flash_on = 1'b0;
        end else begin
            case (req.channel)
                CH_RPM: begin
                    rpm_now = req.value;
                    if (req.value >= lim_shift && !flash_on) begin
                        flash_on  = 1'b1;
                        flash_age = '0;
                    end
                    if (req.value < lim_shift) begin
                        step = (lim_end >= lim_start) ?
                               (int'(lim_end) - int'(lim_start)) / BAR_LEN : 0;
                        for (int i = 0; i < BAR_LEN; i++) begin
                            k = i * 8 / BAR_LEN;
                            if (int'(req.value) <= int'(lim_start) + i * step) begin
                                lamps[i] = PX_OFF;
                            end else if (k < 4) begin
                                lamps[i] = PX_GREEN;
                            end else if (k < 6) begin
                                lamps[i] = PX_AMBER;
                            end else begin
                                lamps[i] = PX_RED;
                            end
                        end
                    end else if (req.value < lim_dark) begin
                        if (amber_age > lim_amber) begin
                            amber_lit = !amber_lit;
                            amber_age = '0;
                            fill_lamps(amber_lit ? PX_AMBER : PX_OFF);
                        end
                    end else begin
                        fill_lamps(PX_OFF);
                    end
                end
                CH_MAP:   map_now = req.value;
                CH_BAT:   battery_now = req.value;
                CH_CLT:   coolant_now = req.value;
                CH_FAULT: fault_bits = COUNT_W'($countones(req.value & FAULT_MASK));
                default: ;
            endcase
        end
        alarm_now = fault_bits != 0 || coolant_now > CLT_LIMIT || rpm_now > RPM_LIMIT ||
                    map_now >= MAP_LIMIT ||
                    (battery_now >= BAT_LOW && battery_now <= BAT_HIGH);
        for (int i = 0; i < BAR_LEN && i < BAR_SHOWN; i++) begin
            r.pixel_codes[CODE_W*i +: CODE_W] = lamps[i];
        end
        r.buzzer       = alarm_now && buzz_ms < BUZZ_ON;
        r.alarm        = alarm_now;
        r.screen_flash = flash_on;
        r.fault_count  = fault_bits;
        return r;
    endfunction

    function automatic stim_row_t row(cmd_t cmd, logic [CHAN_W-1:0] ch, logic [VALUE_W-1:0] v,
                                      logic typed = 1'b0, result_t want = '0);
        stim_row_t s;
        s.req.command = cmd;
        s.req.channel = ch;
        s.req.value   = v;
        s.typed       = typed;
        s.want        = want;
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [CODES_W-1:0] got,
                                   logic [CODES_W-1:0] want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(string what, logic [CODES_W-1:0] got, logic [CODES_W-1:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic send_request(item_t req, logic typed, result_t want);
        int      gap;
        logic    hold;
        result_t guess;
        if (sent_count % 32 == 0) sender_calm = ($urandom_range(3, 0) == 0);
        gap  = sender_calm ? 0 : $urandom_range(13, 0);
        hold = ($urandom_range(49, 0) == 0);
        if (hold && gap == 0) gap = 1;
        if (gap != 0) begin
            s_valid <= 1'b0;
            // Now and then the request waits until the whole pipeline has drained.
            if (hold) begin
                while (dash_due.size() != 0) @(posedge aclk);
            end
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= req.command;
        s_channel <= req.channel;
        s_value   <= req.value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        guess = dash_step(req);
        dash_due.push_back(typed ? want : guess);
        sent_count++;
    endtask

    task automatic write_cfg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            REG_START_RPM:   lim_start = data;
            REG_END_RPM:     lim_end   = data;
            REG_SHIFT_POINT: lim_shift = data;
            REG_DARK_POINT:  lim_dark  = data;
            REG_AMBER_MS:    lim_amber = data[MS_W-1:0];
            REG_FLASH_MS:    lim_flash = data[MS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] bar_lo, logic [CFG_DATA_W-1:0] bar_hi,
                             logic [CFG_DATA_W-1:0] shift_at, logic [CFG_DATA_W-1:0] dark_at,
                             logic [CFG_DATA_W-1:0] amber_ms, logic [CFG_DATA_W-1:0] flash_ms,
                             int count, int tick_pct);
        item_t req;
        int    pick;
        int    mark;
        int    step_now;
        s_valid <= 1'b0;
        while (dash_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_cfg(REG_START_RPM, bar_lo);
        write_cfg(REG_END_RPM, bar_hi);
        write_cfg(REG_SHIFT_POINT, shift_at);
        write_cfg(REG_DARK_POINT, dark_at);
        write_cfg(REG_AMBER_MS, amber_ms);
        write_cfg(REG_FLASH_MS, flash_ms);
        cfg_wr_en <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        step_now = (lim_end >= lim_start) ? (int'(lim_end) - int'(lim_start)) / BAR_LEN : 0;
        for (int n = 0; n < count; n++) begin
            req.command = CMD_FRAME;
            req.channel = CHAN_W'($urandom_range(255, 0));
            req.value   = VALUE_W'($urandom);
            pick        = $urandom_range(9, 0);
            if ($urandom_range(99, 0) < tick_pct) begin
                req.command = CMD_TICK;
            end else if (pick <= 4) begin
                req.channel = CH_RPM;
                case ($urandom_range(5, 0))
                    0: req.value = (lim_shift == 0) ? '0 :
                                   VALUE_W'($urandom_range(int'(lim_shift) - 1, 0));
                    1, 2: req.value = (lim_dark > lim_shift) ?
                               VALUE_W'($urandom_range(int'(lim_dark) - 1, int'(lim_shift))) :
                               VALUE_W'(lim_shift);
                    3: req.value = VALUE_W'($urandom_range(16383, int'(lim_dark)));
                    4: begin
                        case ($urandom_range(3, 0))
                            0: mark = int'(lim_start) + int'($urandom_range(7, 0)) * step_now;
                            1: mark = int'(lim_shift);
                            2: mark = int'(lim_dark);
                            default: mark = int'(RPM_LIMIT);
                        endcase
                        req.value = VALUE_W'(mark + int'($urandom_range(2, 0)) - 1);
                    end
                    default: ;
                endcase
            end else if (pick <= 8) begin
                case (pick)
                    5: begin
                        req.channel = CH_MAP;
                        mark = int'(MAP_LIMIT);
                    end
                    6: begin
                        req.channel = CH_BAT;
                        mark = $urandom_range(1, 0) ? int'(BAT_LOW) : int'(BAT_HIGH);
                    end
                    7: begin
                        req.channel = CH_CLT;
                        mark = int'(CLT_LIMIT);
                    end
                    default: begin
                        req.channel = CH_FAULT;
                        mark = 0;
                    end
                endcase
                case ($urandom_range(3, 0))
                    0: ;
                    1: req.value = '0;
                    default: req.value = (req.channel == CH_FAULT) ?
                                         VALUE_W'(1 << $urandom_range(15, 0)) :
                                         VALUE_W'(mark + int'($urandom_range(4, 0)) - 2);
                endcase
            end
            send_request(req, 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("shift_light_and_engine_alarm regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (dash_due.size() == 0) begin
                report_mismatch("status word with no request pending", m_pixel_codes, '0);
            end else begin
                due_now = dash_due.pop_front();
                check_field("pixel_codes", m_pixel_codes, due_now.pixel_codes);
                check_field("buzzer", m_buzzer, due_now.buzzer);
                check_field("alarm", m_alarm, due_now.alarm);
                check_field("screen_flash", m_screen_flash, due_now.screen_flash);
                check_field("fault_count", m_fault_count, due_now.fault_count);
            end
        end
    end

    initial begin : receive
        int   stall;
        int   taken;
        logic rx_calm;
        taken   = 0;
        rx_calm = 1'b0;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (taken % 32 == 0) rx_calm = ($urandom_range(3, 0) == 0);
            stall = rx_calm ? 0 : $urandom_range(13, 0);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            taken++;
        end
    end

    initial begin : stimulus
        s_valid     <= 1'b0;
        s_command   <= 1'b0;
        s_channel   <= '0;
        s_value     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= '0;
        cfg_wr_data <= '0;
        aresetn     <= 1'b0;

        lim_start   = START_RPM_RST;
        lim_end     = END_RPM_RST;
        lim_shift   = SHIFT_POINT_RST;
        lim_dark    = DARK_POINT_RST;
        lim_amber   = AMBER_MS_RST;
        lim_flash   = FLASH_MS_RST;
        rpm_now     = '0;
        coolant_now = '0;
        map_now     = '0;
        battery_now = '0;
        fault_bits  = '0;
        fill_lamps(PX_DIM);
        amber_lit   = 1'b0;
        amber_age   = '0;
        flash_on    = 1'b0;
        flash_age   = '0;
        buzz_ms     = '0;

        dir_rows.push_back(row(CMD_TICK, 8'd0, 16'h0000, 1'b1, {BAR_DIM, 1'b0, 1'b0, 1'b0, 3'd0}));
        dir_rows.push_back(row(CMD_TICK, CH_FAULT, 16'hFFFF, 1'b1,
                               {BAR_DIM, 1'b0, 1'b0, 1'b0, 3'd0}));
        dir_rows.push_back(row(CMD_FRAME, 8'd0, 16'hFFFF, 1'b1, {BAR_DIM, 1'b0, 1'b0, 1'b0, 3'd0}));
        dir_rows.push_back(row(CMD_FRAME, CH_FAULT, 16'hFFFF, 1'b1,
                               {BAR_DIM, 1'b1, 1'b1, 1'b0, 3'd7}));
        dir_rows.push_back(row(CMD_FRAME, CH_FAULT, 16'h0001));
        dir_rows.push_back(row(CMD_FRAME, CH_FAULT, 16'h0000, 1'b1,
                               {BAR_DIM, 1'b0, 1'b0, 1'b0, 3'd0}));
        dir_rows.push_back(row(CMD_FRAME, CH_RPM, 16'd0, 1'b1, {BAR_DARK, 1'b0, 1'b0, 1'b0, 3'd0}));
        dir_rows.push_back(row(CMD_FRAME, CH_RPM, 16'd1201));
        dir_rows.push_back(row(CMD_FRAME, CH_RPM, 16'd4199));
        dir_rows.push_back(row(CMD_FRAME, CH_RPM, 16'd4200));
        dir_rows.push_back(row(CMD_FRAME, CH_RPM, 16'd4700));
        dir_rows.push_back(row(CMD_FRAME, CH_RPM, 16'hFFFF, 1'b1,
                               {BAR_DARK, 1'b1, 1'b1, 1'b1, 3'd0}));
        dir_rows.push_back(row(CMD_FRAME, CH_RPM, 16'd7001));
        dir_rows.push_back(row(CMD_FRAME, CH_RPM, 16'd7000));
        dir_rows.push_back(row(CMD_FRAME, CH_RPM, 16'd0));
        dir_rows.push_back(row(CMD_FRAME, CH_CLT, 16'd105));
        dir_rows.push_back(row(CMD_FRAME, CH_CLT, 16'd106));
        dir_rows.push_back(row(CMD_FRAME, CH_CLT, 16'd0));
        dir_rows.push_back(row(CMD_FRAME, CH_MAP, 16'd211));
        dir_rows.push_back(row(CMD_FRAME, CH_MAP, 16'd212));
        dir_rows.push_back(row(CMD_FRAME, CH_MAP, 16'd0));
        dir_rows.push_back(row(CMD_FRAME, CH_BAT, 16'd37));
        dir_rows.push_back(row(CMD_FRAME, CH_BAT, 16'd38));
        dir_rows.push_back(row(CMD_FRAME, CH_BAT, 16'd443));
        dir_rows.push_back(row(CMD_FRAME, CH_BAT, 16'd444));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        end

        run_phase(14'd1000, 14'd9000, 14'd6000, 14'd7000, 14'd5, 14'd20, 80, 55);
        run_phase(14'd0, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 60, 50);
        run_phase(14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 40, 50);
        run_phase(14'd3000, 14'd1000, 14'd5000, 14'd9000, 14'd3, 14'd10, 80, 55);
        run_phase(14'd1500, 14'd5500, 14'd6000, 14'd4000, 14'd2, 14'd7, 80, 55);
        run_phase(START_RPM_RST, END_RPM_RST, SHIFT_POINT_RST, DARK_POINT_RST,
                  14'(AMBER_MS_RST), 14'(FLASH_MS_RST), 250, 95);
        run_phase(14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom),
                  14'($urandom_range(40, 0)), 14'($urandom), 100, 55);
        run_phase(14'h3FFF, 14'd0, 14'd1, 14'd2, 14'd1, 14'd1, 40, 50);

        s_valid <= 1'b0;
        while (dash_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("shift_light_and_engine_alarm regression: pass");
        end else begin
            $display("shift_light_and_engine_alarm regression: fail");
        end
        $finish;
    end

endmodule
